FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file of this project.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("check failed");
`endif

FILE: rtl/ptl_pkg.sv
// Package of the page translation block: status codes, register indexes and result word.
// No dependencies.
`timescale 1ns / 1ps
package ptl_pkg;
    localparam logic [1:0] ST_HIT   = 2'd0;
    localparam logic [1:0] ST_FAULT = 2'd1;
    localparam logic [1:0] ST_INVAL = 2'd2;
    localparam logic [1:0] ST_TERM  = 2'd3;

    localparam logic [2:0] REG_FRAME_COUNT = 3'd0;
    localparam logic [2:0] REG_LIMIT_0     = 3'd1;
    localparam logic [2:0] REG_LIMIT_3     = 3'd4;

    // Members run from the highest bits down, so status lands in the lowest bits.
    typedef struct packed {
        logic [15:0] invalid_total;
        logic [15:0] fault_total;
        logic [3:0]  victim_page;
        logic        evicted;
        logic        fault_mapped;
        logic [3:0]  frame;
        logic [1:0]  status;
    } result_t;
endpackage

FILE: rtl/page_translation_local_lru.sv
// Top level of the page translation block with per-process LRU replacement.
// Depends on ptl_pkg.
//
// Use: access and termination words arrive on s_axis (tdata holds mode, process,
// page from the lowest bit up). Each word yields exactly one result word on
// m_axis. Configuration registers are to be written by the user through cfg_we /
// cfg_index / cfg_data only while the block is idle; the block does not enforce it.
// The page table keeps frame and stamp in one synchronous memory with a
// registered read; its valid bits are flip-flops cleared at reset.
// A hit reads the entry and writes back a new stamp; a fault walks the frame
// bitmap one frame a cycle, then, if no frame is free, the process's entries
// one a cycle, and moves the victim's frame; an invalid reference or
// termination walks the process's PAGES entries and frees their frames.
// One item is worked on at a time; the next word is taken once the result
// register is free, so a result waiting on a stalled receiver holds back
// only the next item. Reset empties the page table, frees every frame and
// clears the tick and counters; the registers return to 16.
`timescale 1ns / 1ps
module page_translation_local_lru
    import ptl_pkg::*;
#(
    parameter int PROCESSES = 4,
    parameter int PAGES     = 16,
    parameter int FRAMES    = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [0] mode, [2:1] process, [10:3] page, rest zero
    input  logic [15:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [1:0] status, [5:2] frame, [6] fault_mapped, [7] evicted,
    // [11:8] victim_page, [27:12] fault_total, [43:28] invalid_total, rest zero
    output logic [47:0] m_axis_tdata,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [4:0]  cfg_data
);
    localparam int PW = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int QW = (PROCESSES > 1) ? $clog2(PROCESSES) : 1;
    localparam int EN = PROCESSES * PAGES;
    localparam int EW = (EN > 1) ? $clog2(EN) : 1;

    typedef enum logic [3:0] {
        S_IDLE, S_HITRD, S_HITWR, S_FREE, S_SCAN, S_SCANL, S_EVICT,
        S_REL, S_RELL, S_DONE
    } state_t;

    typedef struct packed {
        logic [FW-1:0] frm;
        logic [31:0]   stamp;
    } ent_t;

    ent_t ent_mem [EN];
    ent_t rd_q;
    logic [EN-1:0] valid_reg;
    logic [FRAMES-1:0] free_reg;
    logic [31:0] tick_reg;
    logic [15:0] fcnt_reg [PROCESSES];
    logic [15:0] icnt_reg [PROCESSES];
    logic [4:0] fc_reg;
    logic [4:0] lim_reg [4];

    state_t state_reg;
    logic [QW-1:0] p_reg;
    logic [7:0] page_reg;
    logic [8:0] idx_reg;
    logic       have_reg;
    logic [PW-1:0] best_reg;
    logic [31:0] bstamp_reg;
    logic [PW:0] prd_reg;    // page whose entry is in rd_q
    logic        out_v_reg;
    result_t     res_reg;

    logic        mem_we;
    logic [EW-1:0] mem_wa, mem_ra;
    ent_t        mem_wd;

    logic [1:0] s_proc;
    logic [QW-1:0] s_p;
    logic [8:0] nfr, lim;
    logic [EW-1:0] cur_e;

    assign s_proc = s_axis_tdata[2:1];
    assign s_axis_tready = (state_reg == S_IDLE) && !out_v_reg;
    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tdata = {4'd0, res_reg};

    // Process indexes beyond the process count wrap round.
    always_comb
    begin
        s_p = '0;
        for (int i = 0; i < 4; i++)
        begin
            if (s_proc == 2'(i))
            begin
                s_p = QW'(i % PROCESSES);
            end
        end
    end

    always_comb
    begin
        nfr = (fc_reg > FRAMES) ? 9'(FRAMES) : 9'(fc_reg);
        lim = (lim_reg[2'(p_reg)] > PAGES) ? 9'(PAGES) : 9'(lim_reg[2'(p_reg)]);
        cur_e = EW'(32'(p_reg) * PAGES + 32'(page_reg));
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            ent_mem[mem_wa] <= mem_wd;
        end
        rd_q <= ent_mem[mem_ra];
    end

    // Memory port control.
    always_comb
    begin
        mem_we = 1'b0;
        mem_wa = cur_e;
        mem_wd = '{frm: rd_q.frm, stamp: tick_reg};
        mem_ra = EW'(32'(p_reg) * PAGES + 32'(idx_reg[PW-1:0]));
        case (state_reg)
            S_HITRD: mem_ra = cur_e;
            S_HITWR: mem_we = 1'b1;
            S_FREE:
            begin
                mem_wd.frm = idx_reg[FW-1:0];
                mem_we = (idx_reg < nfr) && free_reg[idx_reg[FW-1:0]];
            end
            S_RELL: mem_we = 1'b1;
            default: ;
        endcase
        if (state_reg == S_EVICT)
        begin
            mem_ra = EW'(32'(p_reg) * PAGES + 32'(best_reg));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= '0;
            free_reg <= '1;
            tick_reg <= '0;
            for (int i = 0; i < PROCESSES; i++)
            begin
                fcnt_reg[i] <= '0;
                icnt_reg[i] <= '0;
            end
            fc_reg <= 5'd16;
            for (int i = 0; i < 4; i++)
            begin
                lim_reg[i] <= 5'd16;
            end
            out_v_reg <= 1'b0;
            p_reg <= '0;
            page_reg <= '0;
            idx_reg <= '0;
            have_reg <= 1'b0;
            best_reg <= '0;
            bstamp_reg <= '0;
            prd_reg <= '0;
            res_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == REG_FRAME_COUNT)
                begin
                    fc_reg <= cfg_data;
                end
                else if (cfg_index >= REG_LIMIT_0 && cfg_index <= REG_LIMIT_3)
                begin
                    lim_reg[2'(cfg_index - REG_LIMIT_0)] <= cfg_data;
                end
            end
            if (out_v_reg && m_axis_tready)
            begin
                out_v_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (s_axis_tvalid && s_axis_tready)
                    begin
                        p_reg <= s_p;
                        page_reg <= s_axis_tdata[10:3];
                        res_reg <= '0;
                        idx_reg <= '0;
                        have_reg <= 1'b0;
                        if (s_axis_tdata[0])
                        begin
                            res_reg.status <= ST_TERM;
                            state_reg <= S_REL;
                        end
                        else
                        begin
                            state_reg <= S_HITRD;
                        end
                    end
                end
                S_HITRD:
                begin
                    if (9'(page_reg) >= lim)
                    begin
                        res_reg.status <= ST_INVAL;
                        if (icnt_reg[p_reg] != 16'hFFFF)
                        begin
                            icnt_reg[p_reg] <= icnt_reg[p_reg] + 16'd1;
                        end
                        state_reg <= S_REL;
                    end
                    else if (valid_reg[cur_e])
                    begin
                        res_reg.status <= ST_HIT;
                        state_reg <= S_HITWR;
                    end
                    else
                    begin
                        res_reg.status <= ST_FAULT;
                        if (fcnt_reg[p_reg] != 16'hFFFF)
                        begin
                            fcnt_reg[p_reg] <= fcnt_reg[p_reg] + 16'd1;
                        end
                        state_reg <= S_FREE;
                    end
                end
                S_HITWR:
                begin
                    res_reg.frame <= 4'(rd_q.frm);
                    state_reg <= S_DONE;
                end
                S_FREE:
                begin
                    if (idx_reg >= nfr)
                    begin
                        idx_reg <= '0;
                        state_reg <= S_SCAN;
                    end
                    else if (free_reg[idx_reg[FW-1:0]])
                    begin
                        free_reg[idx_reg[FW-1:0]] <= 1'b0;
                        valid_reg[cur_e] <= 1'b1;
                        res_reg.frame <= 4'(idx_reg);
                        res_reg.fault_mapped <= 1'b1;
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 9'd1;
                    end
                end
                S_SCAN, S_SCANL:
                begin
                    // rd_q holds the entry of page prd_reg when S_SCANL or idx>0
                    if (state_reg == S_SCANL || idx_reg != '0)
                    begin
                        if (valid_reg[EW'(32'(p_reg) * PAGES + 32'(prd_reg[PW-1:0]))]
                            && (!have_reg || rd_q.stamp < bstamp_reg))
                        begin
                            have_reg <= 1'b1;
                            best_reg <= prd_reg[PW-1:0];
                            bstamp_reg <= rd_q.stamp;
                        end
                    end
                    prd_reg <= (PW+1)'(idx_reg);
                    if (state_reg == S_SCANL)
                    begin
                        state_reg <= S_EVICT;
                    end
                    else if (32'(idx_reg) == PAGES - 1)
                    begin
                        state_reg <= S_SCANL;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 9'd1;
                    end
                end
                S_EVICT:
                begin
                    // rd_q is stale here; victim frame read lands next cycle
                    if (have_reg)
                    begin
                        state_reg <= S_RELL;
                    end
                    else
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_RELL:
                begin
                    // victim entry now in rd_q: move its frame to the new page
                    valid_reg[EW'(32'(p_reg) * PAGES + 32'(best_reg))] <= 1'b0;
                    valid_reg[cur_e] <= 1'b1;
                    res_reg.frame <= 4'(rd_q.frm);
                    res_reg.fault_mapped <= 1'b1;
                    res_reg.evicted <= 1'b1;
                    res_reg.victim_page <= 4'(best_reg);
                    state_reg <= S_DONE;
                end
                S_REL:
                begin
                    // Frames are held in the memory; read each entry, free next cycle.
                    if (idx_reg != '0 &&
                        valid_reg[EW'(32'(p_reg) * PAGES + 32'(prd_reg[PW-1:0]))])
                    begin
                        free_reg[rd_q.frm] <= 1'b1;
                        valid_reg[EW'(32'(p_reg) * PAGES + 32'(prd_reg[PW-1:0]))] <= 1'b0;
                    end
                    prd_reg <= (PW+1)'(idx_reg);
                    if (32'(idx_reg) == PAGES)
                    begin
                        state_reg <= S_DONE;
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 9'd1;
                    end
                end
                S_DONE:
                begin
                    if (!out_v_reg)
                    begin
                        res_reg.fault_total <= fcnt_reg[p_reg];
                        res_reg.invalid_total <= icnt_reg[p_reg];
                        out_v_reg <= 1'b1;
                        if (tick_reg != 32'hFFFF_FFFF)
                        begin
                            tick_reg <= tick_reg + 32'd1;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

FILE: rtl/ptl_checker.sv
// Port checker for the page translation block, bound to the top level.
// Depends on ptl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ptl_checker
    import ptl_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);
    // No new word is taken while a result waits.
    `CHK_IMPLY(a_no_take, clk, rst_n, m_axis_tvalid, !s_axis_tready)
    // A result that waits keeps its data.
    `CHK_NEXT(a_hold, clk, rst_n, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata))
    // A fault without a frame shows no eviction.
    `CHK_IMPLY(a_evict, clk, rst_n, m_axis_tvalid && m_axis_tdata[7], m_axis_tdata[6])
    // Only faults map or evict.
    `CHK_IMPLY(a_map, clk, rst_n, m_axis_tvalid && m_axis_tdata[6],
               m_axis_tdata[1:0] == ST_FAULT)
endmodule

bind page_translation_local_lru ptl_checker u_ptl_checker (.*);
